FILE: hdl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, defaults, status codes and the finder result type.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAX_BLOCKS_DEF = 4096;
	localparam int WORD_BITS_DEF  = 64;

	localparam int BN_W   = 12;
	localparam int CNT_W  = 13;
	localparam int ST_W   = 2;
	localparam int BASE_W = 14;
	localparam int IDX_W  = 6;

	localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;

	typedef enum logic [ST_W-1:0] {
		ST_OK           = 2'd0,
		ST_FULL         = 2'd1,
		ST_ALREADY_FREE = 2'd2,
		ST_RANGE        = 2'd3
	} status_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} find_t;

endpackage

FILE: hdl/bba_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator free-bit finder
// Lowest clear bit of one bitmap word among the bits that lie below the limit.
// ----------------------------------------------------------------------------
module bba_find #(
	parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
	input  logic [WORD_BITS-1:0]      word,
	input  logic [bba_pkg::BASE_W-1:0] room,
	output bba_pkg::find_t             res
);

	logic [WORD_BITS-1:0] avail;
	logic [WORD_BITS-1:0] lowest;
	logic [bba_pkg::IDX_W-1:0] idx;

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			avail[i] = !word[i] && (bba_pkg::BASE_W'(i) < room);
		end
	end

	assign lowest = avail & (~avail + WORD_BITS'(1));

	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowest[i]) begin
				idx = idx | bba_pkg::IDX_W'(i);
			end
		end
	end

	assign res.found = |avail;
	assign res.idx   = idx;

endmodule

FILE: hdl/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit block allocator over an in-use bitmap held in a word-wide RAM.
//
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_wr_en              cfg_wr_data (total_blocks)
// in        in         in_valid / in_ready    op, block_number
// out       out        out_valid / out_ready  granted_block, status, used_count
//
// Allocate: scans the bitmap words in order, one RAM read a cycle, up to
// NUM_WORDS words, until the first free bit below the limit is found.
// Free: quotient, read, write back, result; out of range skips to result.
// Words at or above the fill mark read as zero; reset needs no clearing pass.
// One item at a time; a pending result waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
	parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [bba_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic [bba_pkg::BN_W-1:0]  block_number,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bba_pkg::BN_W-1:0]  granted_block,
	output logic [bba_pkg::ST_W-1:0]  status,
	output logic [bba_pkg::CNT_W-1:0] used_count
);

	localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int HW_W      = $clog2(NUM_WORDS + 1);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int DIV_K     = bba_pkg::BN_W + BIT_W;
	localparam int MW        = bba_pkg::BN_W + 1;
	localparam int DIV_M     = ((1 << DIV_K) + WORD_BITS - 1) / WORD_BITS;
	localparam int PW        = bba_pkg::BN_W + MW;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_SCAN    = 6'b000010,
		S_DIV     = 6'b000100,
		S_FREE_RD = 6'b001000,
		S_FREE_WR = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	state_t                       state_q;
	logic [bba_pkg::CNT_W-1:0]    total_q;
	logic [bba_pkg::CNT_W-1:0]    count_q;
	logic [HW_W-1:0]              hwm_q;
	logic                         out_valid_q;
	logic                         chk_vld_s1;

	logic [bba_pkg::BN_W-1:0]     blk_q;
	logic [bba_pkg::BN_W-1:0]     word_q;
	logic [BIT_W-1:0]             bit_q;
	logic [bba_pkg::BASE_W-1:0]   iss_base_q;
	logic [AW-1:0]                iss_addr_q;
	logic [bba_pkg::BASE_W-1:0]   chk_base_s1;
	logic [AW-1:0]                chk_addr_s1;
	logic [bba_pkg::BN_W-1:0]     res_granted_q;
	bba_pkg::status_t             res_status_q;
	logic [bba_pkg::BN_W-1:0]     out_granted_q;
	bba_pkg::status_t             out_status_q;
	logic [bba_pkg::CNT_W-1:0]    out_used_q;

	logic [WORD_BITS-1:0]         mem [NUM_WORDS];
	logic [WORD_BITS-1:0]         rd_data_q;

	logic [bba_pkg::CNT_W-1:0]    limit;
	logic                         issue;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [WORD_BITS-1:0]         wr_data;
	logic [WORD_BITS-1:0]         chk_word;
	logic [WORD_BITS-1:0]         free_word;
	logic                         bit_set;
	logic [bba_pkg::BASE_W-1:0]   room;
	bba_pkg::find_t               fnd;
	logic                         alloc_hit;
	logic                         can_load;
	logic [PW-1:0]                prod;
	logic [bba_pkg::BN_W-1:0]     quot;
	logic [bba_pkg::BN_W-1:0]     quot_w;

	always_comb begin
		if (32'(total_q) > MAX_BLOCKS) begin
			limit = bba_pkg::CNT_W'(MAX_BLOCKS);
		end else begin
			limit = total_q;
		end
	end

	assign issue = (state_q == S_SCAN) && (iss_base_q < bba_pkg::BASE_W'(limit));

	assign chk_word  = (32'(chk_addr_s1) >= 32'(hwm_q)) ? '0 : rd_data_q;
	assign free_word = (32'(word_q) >= 32'(hwm_q)) ? '0 : rd_data_q;
	assign bit_set   = free_word[bit_q];
	assign room      = bba_pkg::BASE_W'(limit) - chk_base_s1;

	bba_find #(
		.WORD_BITS(WORD_BITS)
	) u_find (
		.word(chk_word),
		.room(room),
		.res (fnd)
	);

	assign alloc_hit = (state_q == S_SCAN) && chk_vld_s1 && fnd.found;
	assign can_load  = !out_valid_q || out_ready;

	// quotient by reciprocal; exact for every 12-bit block number
	assign prod   = PW'(blk_q) * PW'(DIV_M);
	assign quot   = bba_pkg::BN_W'(prod >> DIV_K);
	assign quot_w = bba_pkg::BN_W'(word_q * bba_pkg::BN_W'(WORD_BITS));

	always_comb begin
		rd_en   = issue || (state_q == S_FREE_RD);
		rd_addr = (state_q == S_FREE_RD) ? AW'(word_q) : iss_addr_q;
		wr_en   = 1'b0;
		wr_addr = chk_addr_s1;
		wr_data = chk_word | (WORD_BITS'(1) << fnd.idx);
		if (alloc_hit) begin
			wr_en = 1'b1;
		end else if ((state_q == S_FREE_WR) && bit_set) begin
			wr_en   = 1'b1;
			wr_addr = AW'(word_q);
			wr_data = free_word & ~(WORD_BITS'(1) << bit_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= bba_pkg::TOTAL_RESET;
			count_q     <= '0;
			hwm_q       <= '0;
			out_valid_q <= 1'b0;
			chk_vld_s1  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
			end
			if ((state_q == S_DONE) && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					chk_vld_s1 <= 1'b0;
					if (in_valid) begin
						state_q <= op ? S_DIV : S_SCAN;
					end
				end
				S_SCAN: begin
					chk_vld_s1 <= issue;
					if (alloc_hit) begin
						count_q <= count_q + 1'b1;
						if (32'(chk_addr_s1) == 32'(hwm_q)) begin
							hwm_q <= hwm_q + 1'b1;
						end
						state_q <= S_DONE;
					end else if (!chk_vld_s1 && !issue) begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if ({1'b0, blk_q} >= limit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_FREE_RD;
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					if (bit_set) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					blk_q         <= block_number;
					iss_base_q    <= '0;
					iss_addr_q    <= '0;
					res_granted_q <= '0;
					res_status_q  <= bba_pkg::ST_FULL;
				end
			end
			S_SCAN: begin
				if (issue) begin
					iss_addr_q <= iss_addr_q + 1'b1;
					iss_base_q <= iss_base_q + bba_pkg::BASE_W'(WORD_BITS);
				end
				chk_base_s1 <= iss_base_q;
				chk_addr_s1 <= iss_addr_q;
				if (alloc_hit) begin
					res_granted_q <= bba_pkg::BN_W'(chk_base_s1 + bba_pkg::BASE_W'(fnd.idx));
					res_status_q  <= bba_pkg::ST_OK;
				end
			end
			S_DIV: begin
				word_q       <= quot;
				res_status_q <= bba_pkg::ST_RANGE;
			end
			S_FREE_RD: begin
				bit_q <= BIT_W'(blk_q - quot_w);
			end
			S_FREE_WR: begin
				res_status_q <= bit_set ? bba_pkg::ST_OK : bba_pkg::ST_ALREADY_FREE;
			end
			S_DONE: begin
				if (can_load) begin
					out_granted_q <= res_granted_q;
					out_status_q  <= res_status_q;
					out_used_q    <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign granted_block = out_granted_q;
	assign status        = out_status_q;
	assign used_count    = out_used_q;

endmodule

FILE: hdl/bba_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator port checker
// Watches the allocator's ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module bba_check #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [bba_pkg::BN_W-1:0]  granted_block,
	input logic [bba_pkg::ST_W-1:0]  status,
	input logic [bba_pkg::CNT_W-1:0] used_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted_block) &&
			$stable(status) && $stable(used_count))
		else $error("result changed while stalled");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != bba_pkg::ST_OK) |-> (granted_block == '0))
		else $error("granted block nonzero on a failed request");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (MAX_BLOCKS >= (1 << bba_pkg::CNT_W)) ||
			(32'(used_count) <= MAX_BLOCKS))
		else $error("used count above block capacity");

endmodule

bind bitmap_block_allocator bba_check #(
	.MAX_BLOCKS(MAX_BLOCKS)
) u_bba_check (.*);
